// File: sv/tdts_pkg.sv
package tdts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int CNT_W  = 9;
  localparam int PRIO_W = 8;
  localparam int SEED_W = 16;

  localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SEED   = 1'b1;

  // item modes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_CREATE = 1'b1;

  // refill policies
  localparam logic POLICY_RANDOM = 1'b0;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [3:0]       run_task;
    logic [CNT_W-1:0] run_cnt;
    logic             switched;
    logic [1:0]       status;
  } res_t;

  // s mod 10 plus 1; floor(s/10) by reciprocal, exact below 81920
  function automatic logic [3:0] refill_draw(input logic [SEED_W-1:0] s);
    logic [31:0] prod;
    logic [12:0] q;
    logic [15:0] r;
    prod = 32'(s) * 32'd52429;
    q    = prod[31:19];
    r    = s - 16'(q) * 16'd10;
    return r[3:0] + 4'd1;
  endfunction

endpackage

// File: sv/tdts_ram.sv
module tdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tdts_lfsr.sv
module tdts_lfsr (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seed_load,
  input  logic [tdts_pkg::SEED_W-1:0] seed,
  input  logic                        step,
  output logic [tdts_pkg::CNT_W-1:0]  draw
);

  import tdts_pkg::*;

  logic [SEED_W-1:0] lfsr;
  logic [SEED_W-1:0] lfsr_next;
  logic [SEED_W-1:0] shifted;

  always_comb begin
    shifted = {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_MASK : '0);
    lfsr_next = (shifted == '0) ? SEED_W'(1) : shifted;
  end

  assign draw = CNT_W'(refill_draw(lfsr_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_W'(1);
    end else if (seed_load) begin
      // zero would lock the generator
      lfsr <= (seed == '0) ? SEED_W'(1) : seed;
    end else if (step) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

// File: sv/tdts_ctrl.sv
module tdts_ctrl #(
  parameter int MAX_TASKS = tdts_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [tdts_pkg::PRIO_W-1:0] new_priority,
  input  logic                        policy,
  input  logic [tdts_pkg::CNT_W-1:0]  draw,
  output logic                        lfsr_step,
  input  logic                        out_free,
  output logic                        res_load,
  output tdts_pkg::res_t              res
);

  import tdts_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_REFILL = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [IW-1:0]    task_count, task_count_next;
  logic [IW-1:0]    cur, cur_next;
  logic [CNT_W-1:0] cur_cnt, cur_cnt_next;
  logic [IW:0]      issue_idx, issue_idx_next;
  logic             data_vld, data_vld_next;
  logic [IW-1:0]    data_idx, data_idx_next;
  logic             found, found_next;
  logic [IW-1:0]    best_idx, best_idx_next;
  logic [CNT_W-1:0] best_cnt, best_cnt_next;
  res_t             res_next;

  logic              cnt_we;
  logic [IW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              prio_we;
  logic [IW-1:0]     new_slot;
  logic [PRIO_W-1:0] prio_rdata;

  logic             accept;
  logic             issue_done;
  logic             pass_end;
  logic [CNT_W-1:0] val;
  logic [CNT_W-1:0] halved_val;

  tdts_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TASKS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (issue_idx[IW-1:0]),
    .rdata (cnt_rdata)
  );

  tdts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (new_slot),
    .wdata (new_priority),
    .raddr (issue_idx[IW-1:0]),
    .rdata (prio_rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign new_slot   = task_count + IW'(1);
  assign issue_done = (issue_idx > {1'b0, task_count});
  assign pass_end   = issue_done && !data_vld;

  // both RAMs are read at the issue index, so their data line up with data_idx
  assign halved_val = CNT_W'({1'b0, cnt_rdata[CNT_W-1:1]}) + CNT_W'(prio_rdata);
  assign val = (state == S_REFILL) ? ((policy == POLICY_RANDOM) ? draw : halved_val)
                                   : cnt_rdata;

  always_comb begin
    state_next      = state;
    task_count_next = task_count;
    cur_next        = cur;
    cur_cnt_next    = cur_cnt;
    issue_idx_next  = issue_idx;
    data_vld_next   = 1'b0;
    data_idx_next   = data_idx;
    found_next      = found;
    best_idx_next   = best_idx;
    best_cnt_next   = best_cnt;
    res_next        = res;
    cnt_we          = 1'b0;
    cnt_waddr       = data_idx;
    cnt_wdata       = val;
    prio_we         = 1'b0;
    lfsr_step       = 1'b0;
    res_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_CREATE) begin
            if (task_count == LAST_SLOT) begin
              res_next = '{4'(cur), cur_cnt, 1'b0, ST_FULL};
            end else begin
              task_count_next = new_slot;
              cnt_we          = 1'b1;
              cnt_waddr       = new_slot;
              cnt_wdata       = '0;
              prio_we         = 1'b1;
              res_next        = '{4'(cur), cur_cnt, 1'b0, ST_OK};
            end
            state_next = S_DONE;
          end else if (cur != '0 && cur_cnt != '0) begin
            cnt_we       = 1'b1;
            cnt_waddr    = cur;
            cnt_wdata    = cur_cnt - CNT_W'(1);
            cur_cnt_next = cur_cnt - CNT_W'(1);
            res_next     = '{4'(cur), cur_cnt - CNT_W'(1), 1'b0, ST_OK};
            state_next   = S_DONE;
          end else begin
            issue_idx_next = (IW+1)'(1);
            found_next     = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN, S_REFILL: begin
        if (!issue_done) begin
          issue_idx_next = issue_idx + (IW+1)'(1);
          data_vld_next  = 1'b1;
          data_idx_next  = issue_idx[IW-1:0];
        end
        if (data_vld) begin
          if (state == S_REFILL) begin
            cnt_we    = 1'b1;
            lfsr_step = (policy == POLICY_RANDOM);
          end
          if (!found || val > best_cnt) begin
            found_next    = 1'b1;
            best_idx_next = data_idx;
            best_cnt_next = val;
          end
        end
        if (pass_end) begin
          if (!found || (state == S_REFILL && best_cnt == '0)) begin
            // nothing runnable: fall back to the idle task
            cur_next     = '0;
            cur_cnt_next = '0;
            res_next     = '{4'd0, '0, (cur != '0), ST_NONE};
            state_next   = S_DONE;
          end else if (best_cnt != '0) begin
            cur_next     = best_idx;
            cur_cnt_next = best_cnt;
            res_next     = '{4'(best_idx), best_cnt, (best_idx != cur), ST_OK};
            state_next   = S_DONE;
          end else begin
            issue_idx_next = (IW+1)'(1);
            found_next     = 1'b0;
            state_next     = S_REFILL;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      cur        <= '0;
      cur_cnt    <= '0;
      data_vld   <= 1'b0;
      found      <= 1'b0;
    end else begin
      state      <= state_next;
      task_count <= task_count_next;
      cur        <= cur_next;
      cur_cnt    <= cur_cnt_next;
      data_vld   <= data_vld_next;
      found      <= found_next;
    end
    issue_idx <= issue_idx_next;
    data_idx  <= data_idx_next;
    best_idx  <= best_idx_next;
    best_cnt  <= best_cnt_next;
    res       <= res_next;
  end

endmodule

// File: sv/tick_driven_task_scheduler_top.sv
// Create, and a tick that only decrements the running counter, go from acceptance
// straight to the done state, where the result waits for the output register. A scheduling
// tick scans the counter RAM one task per cycle; if every counter is zero, a refill pass follows.
// One item is in work at a time; the next one is taken once the result has
// moved to the output register. Synchronous reset empties the task table,
// selects the idle task and loads the generator with 1; the RAMs are not cleared.
module tick_driven_task_scheduler_top #(
  parameter int MAX_TASKS = tdts_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [tdts_pkg::PRIO_W-1:0]   new_priority,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    running_task,
  output logic [tdts_pkg::CNT_W-1:0]    running_counter,
  output logic                          switched,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tdts_pkg::SEED_W-1:0]   cfg_data
);

  import tdts_pkg::*;

  logic             policy;
  logic             cfg_we;
  logic [CNT_W-1:0] draw;
  logic             lfsr_step;
  logic             out_free;
  logic             res_load;
  res_t             res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_RANDOM;
    end else if (cfg_we && cfg_index == CFG_POLICY) begin
      policy <= cfg_data[0];
    end
  end

  tdts_lfsr u_lfsr (
    .clk       (clk),
    .rst       (rst),
    .seed_load (cfg_we && cfg_index == CFG_SEED),
    .seed      (cfg_data),
    .step      (lfsr_step),
    .draw      (draw)
  );

  tdts_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .new_priority (new_priority),
    .policy       (policy),
    .draw         (draw),
    .lfsr_step    (lfsr_step),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      running_task    <= res.run_task;
      running_counter <= res.run_cnt;
      switched        <= res.switched;
      status          <= res.status;
    end
  end

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdts_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;
  localparam logic POLICY_PRIO = 1'b1;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [PRIO_W-1:0] new_priority;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        running_task;
  logic [CNT_W-1:0]  running_counter;
  logic              switched;
  logic [1:0]        status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [SEED_W-1:0] cfg_data;

  tick_driven_task_scheduler_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .new_priority    (new_priority),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .running_task    (running_task),
    .running_counter (running_counter),
    .switched        (switched),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // scheduler shadow state
  logic [CNT_W-1:0]  cnt_tbl [SLOTS];
  logic [PRIO_W-1:0] prio_tbl [SLOTS];
  logic [3:0]        cur_task;
  int                n_tasks;
  logic              pol;
  logic [SEED_W-1:0] lfsr;

  res_t expected_runs [$];
  int   err_count;

  bit tx_idle_en;
  bit rx_idle_en;
  int hold_req;
  int stall_left;
  bit stall_now;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CNT_W-1:0] next_draw();
    logic [SEED_W-1:0] s;
    s = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : '0);
    if (s == '0) s = 16'd1;
    lfsr = s;
    return CNT_W'(s % 16'd10) + 9'd1;
  endfunction

  function automatic void refill_counters();
    for (int i = 1; i <= n_tasks; i++) begin
      if (pol == POLICY_PRIO)
        cnt_tbl[i] = (cnt_tbl[i] >> 1) + CNT_W'(prio_tbl[i]);
      else
        cnt_tbl[i] = next_draw();
    end
  endfunction

  // largest counter wins, lowest index on a tie; 0 when the table is empty
  function automatic logic [3:0] choose_task(output logic [CNT_W-1:0] best);
    logic [3:0] sel;
    logic       found;
    sel = '0;
    found = 1'b0;
    best = '0;
    for (int i = 1; i <= n_tasks; i++) begin
      if (!found || cnt_tbl[i] > best) begin
        found = 1'b1;
        best = cnt_tbl[i];
        sel = 4'(i);
      end
    end
    return sel;
  endfunction

  function automatic logic [1:0] reschedule();
    logic [3:0]       sel;
    logic [CNT_W-1:0] c;
    sel = choose_task(c);
    if (sel != '0 && c == '0) begin
      refill_counters();
      sel = choose_task(c);
    end
    if (sel == '0 || c == '0) begin
      cur_task = '0;
      return ST_NONE;
    end
    cur_task = sel;
    return ST_OK;
  endfunction

  function automatic res_t schedule_item(input logic m, input logic [PRIO_W-1:0] p);
    res_t       r;
    logic [3:0] prev;
    logic [1:0] st;
    prev = cur_task;
    st = ST_OK;
    if (m == MODE_CREATE) begin
      if (n_tasks == SLOTS - 1) begin
        st = ST_FULL;
      end else begin
        n_tasks++;
        cnt_tbl[n_tasks] = '0;
        prio_tbl[n_tasks] = p;
      end
    end else if (cur_task == '0 || cnt_tbl[cur_task] == '0) begin
      st = reschedule();
    end else begin
      cnt_tbl[cur_task] = cnt_tbl[cur_task] - 9'd1;
    end
    r.run_task = cur_task;
    r.run_cnt  = cnt_tbl[cur_task];
    r.switched = (cur_task != prev);
    r.status   = st;
    return r;
  endfunction

  task automatic send_item(input logic m, input logic [PRIO_W-1:0] p);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    new_priority <= p;
    do @(posedge clk); while (in_stall);
    expected_runs.push_back(schedule_item(m, p));
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_runs.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [SEED_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY)
      pol = val[0];
    else
      lfsr = (val == '0) ? 16'd1 : val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int n);
    logic m;
    for (int k = 0; k < n; k++) begin
      m = ($urandom_range(0, 9) == 0) ? MODE_CREATE : MODE_TICK;
      send_item(m, PRIO_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_empty_table();
    write_reg(CFG_POLICY, {15'h7fff, POLICY_PRIO});
    write_reg(CFG_SEED, 16'hffff);
    send_item(MODE_TICK, 8'hff);
    send_item(MODE_TICK, 8'h00);
  endtask

  // zero priorities under the priority policy refill to zero: idle runs
  task automatic test_zero_refill();
    send_item(MODE_CREATE, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_CREATE, 8'h00);
    send_item(MODE_TICK, 8'hff);
    send_item(MODE_TICK, 8'h00);
  endtask

  task automatic test_priority_refill();
    send_item(MODE_CREATE, 8'hff);
    send_item(MODE_CREATE, 8'h01);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_TICK, 8'h00);
  endtask

  task automatic test_seed_zero();
    settle();
    write_reg(CFG_POLICY, 16'h0000 | POLICY_RANDOM);
    write_reg(CFG_SEED, 16'h0000);
    send_item(MODE_CREATE, 8'h80);
    send_item(MODE_TICK, 8'h00);
  endtask

  task automatic test_table_full();
    while (n_tasks < SLOTS - 1)
      send_item(MODE_CREATE, PRIO_W'($urandom_range(0, 255)));
    send_item(MODE_CREATE, 8'h7f);
    send_item(MODE_TICK, 8'h00);
  endtask

  task automatic test_random_phases();
    logic [SEED_W-1:0] seed;
    logic              p;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          p = POLICY_RANDOM;
          seed = 16'h0001;
        end
        1: begin
          p = POLICY_PRIO;
          seed = 16'hffff;
        end
        default: begin
          p = ($urandom_range(0, 2) == 0) ? POLICY_PRIO : POLICY_RANDOM;
          seed = SEED_W'($urandom_range(1, 65535));
        end
      endcase
      write_reg(CFG_POLICY, {15'($urandom_range(0, 32767)), p});
      write_reg(CFG_SEED, seed);
      tx_idle_en = (ph % 4 != 3);
      rx_idle_en = (ph % 4 != 3);
      random_items(130);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_req = 400;
    random_items(25);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    random_items(40);
    settle();
    random_items(40);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result transaction: task %0d counter %0d",
               running_task, running_counter);
        err_count++;
      end else begin
        want = expected_runs.pop_front();
        if (running_task !== want.run_task) begin
          $error("running_task: expected %0d, actual %0d", want.run_task, running_task);
          err_count++;
        end
        if (running_counter !== want.run_cnt) begin
          $error("running_counter: expected %0d, actual %0d", want.run_cnt,
                 running_counter);
          err_count++;
        end
        if (switched !== want.switched) begin
          $error("switched: expected %0d, actual %0d", want.switched, switched);
          err_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          err_count++;
        end
      end
    end
  end

  // receiver stall generator
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left == 0 && rx_idle_en)
        stall_left = idle_len();
      stall_now = (stall_left > 0);
      if (stall_now) stall_left--;
      out_stall <= stall_now;
    end
  end

  initial begin
    #1_600_000;
    $display("tick_driven_task_scheduler_top test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_TICK;
    new_priority = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_data = '0;
    err_count = 0;
    hold_req = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      cnt_tbl[i] = '0;
      prio_tbl[i] = '0;
    end
    cur_task = '0;
    n_tasks = 0;
    pol = POLICY_RANDOM;
    lfsr = 16'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_zero_refill();
    test_priority_refill();
    test_seed_zero();
    test_table_full();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();

    settle();
    repeat (60) @(posedge clk);
    if (expected_runs.size() != 0) begin
      $error("%0d result transactions never arrived", expected_runs.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tick_driven_task_scheduler_top test passed");
    end else begin
      $display("tick_driven_task_scheduler_top test failed");
    end
    $finish;
  end

endmodule
